// ===== rtl/chi_square_histogram_distance_core_assert.svh =====
// Assertion macros shared by the RTL modules.
// Each use names a label, a clock, a reset, an antecedent, a consequent and a message.
`ifndef CHI_SQUARE_HISTOGRAM_DISTANCE_CORE_ASSERT_SVH
`define CHI_SQUARE_HISTOGRAM_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CHSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chsq_pkg.sv =====
package chsq_pkg;

    localparam int BIN_W     = 32;
    localparam int DEN_W     = BIN_W + 1;
    localparam int DIST_W    = 48;
    localparam int DIV_STEPS = BIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0] TOTAL_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SQUARE,
        S_DIV,
        S_ACC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic square;
        logic div_step;
        logic acc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/chsq_ctrl.sv =====
`include "chi_square_histogram_distance_core_assert.svh"

module chsq_ctrl
    import chsq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                // a last word needs room in the output register
                if (!i_status.last || i_status.out_free) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CHSQ_ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "cmd not onehot0")
    `CHSQ_ASSERT_NEXT(a_div_to_acc, i_clk, i_rst_n,
        r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1), r_state == S_ACC,
        "divide did not end in accumulate")
    `CHSQ_ASSERT_NEXT(a_load_to_prep, i_clk, i_rst_n, o_cmd.load,
        r_state == S_PREP && o_in_stall, "accepted word did not start work")

endmodule

// ===== rtl/chsq_datapath.sv =====
`include "chi_square_histogram_distance_core_assert.svh"

module chsq_datapath
    import chsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [BIN_W-1:0]  i_bin_first,
    input  logic [BIN_W-1:0]  i_bin_second,
    input  logic              i_last_bin,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_saturated
);

    logic [BIN_W-1:0]  r_a, r_b;
    logic              r_last;
    logic [BIN_W-1:0]  r_diff;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [BIN_W-1:0]  r_quo;
    logic [DIST_W-1:0] r_total;
    logic              r_sat;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_distance;
    logic              r_saturated;

    logic [2*BIN_W-1:0] square;
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [DEN_W:0]     rem_sub;
    logic [BIN_W-1:0]   quotient;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  n_total;
    logic               n_sat;
    logic               out_free;

    assign square  = r_diff * r_diff;
    // restoring step: shift next dividend bit in from the low half
    assign rem_sh  = {r_rem, r_quo[BIN_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // an all-zero pair would read as all ones from the divider
    assign quotient = (r_den == '0) ? '0 : r_quo;
    assign sum      = {1'b0, r_total} + {{(DIST_W - BIN_W + 1){1'b0}}, quotient};
    assign n_total  = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[DIST_W-1:0];
    assign n_sat    = r_sat || (n_total == TOTAL_MAX);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_bin_first;
            r_b    <= i_bin_second;
            r_last <= i_last_bin;
        end
        if (i_cmd.prep) begin
            r_diff <= (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
            r_den  <= {1'b0, r_a} + {1'b0, r_b};
        end
        if (i_cmd.square) begin
            // quotient fits in BIN_W bits, so the high half is already below the divisor
            r_rem <= {1'b0, square[2*BIN_W-1:BIN_W]};
            r_quo <= square[BIN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[BIN_W-2:0], rem_ge};
        end
        if (i_cmd.acc && r_last) begin
            r_distance  <= n_total;
            r_saturated <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_total <= r_last ? '0 : n_total;
                r_sat   <= r_last ? 1'b0 : n_sat;
            end
            if (i_cmd.acc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_saturated = r_saturated;

    `CHSQ_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, i_cmd.div_step && r_den != '0,
        r_rem < r_den, "divider remainder not below divisor")
    `CHSQ_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, i_cmd.acc && r_last,
        r_out_valid && r_total == '0 && !r_sat, "last word did not emit and clear")
    `CHSQ_ASSERT_IMPL(a_acc_room, i_clk, i_rst_n, i_cmd.acc && r_last,
        out_free, "result overwrote a pending word")

endmodule

// ===== rtl/chi_square_histogram_distance_core.sv =====
// Chi-square histogram distance. Feed matching bins of two histograms
// (unsigned Q16.16) one pair per word, with i_last_bin set on the final
// pair; that pair returns one word with the distance (unsigned Q32.16,
// sticking at all ones) and a flag that is set if the total reached its
// maximum. Each pair adds (a-b)^2/(a+b), truncated; a pair of zeros adds
// nothing. The core works on one pair at a time, from its acceptance to the
// next acceptance: the accepting cycle, difference and sum, one 32x32 square,
// a one-bit-per-cycle restoring divider, one accumulate. A last pair waits in
// the accumulate step until the output register has room for its word. A new
// pair is taken while a finished result is still held.
module chi_square_histogram_distance_core
    import chsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BIN_W-1:0]  i_bin_first,
    input  logic [BIN_W-1:0]  i_bin_second,
    input  logic              i_last_bin,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_saturated
);

    t_cmd    cmd;
    t_status status;

    chsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    chsq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_bin_first  (i_bin_first),
        .i_bin_second (i_bin_second),
        .i_last_bin   (i_last_bin),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_distance   (o_distance),
        .o_saturated  (o_saturated)
    );

endmodule

// ===== tb/sv/chi_square_histogram_distance_checker.sv =====
`timescale 1ns / 1ps

module chi_square_histogram_distance_checker
    import chsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BIN_W-1:0]  i_bin_first,
    input  logic [BIN_W-1:0]  i_bin_second,
    input  logic              i_last_bin,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DIST_W-1:0] i_distance,
    input  logic              i_saturated,
    output int                o_error_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } t_chi_result;

    t_chi_result       expected_distances[$];
    logic [DIST_W-1:0] hist_total;
    logic              hist_sat;
    int                err_count = 0;

    // (a-b)^2 / (a+b), exact, truncated; zero when both bins are zero
    function automatic logic [BIN_W-1:0] chi_term(input logic [BIN_W-1:0] a,
                                                  input logic [BIN_W-1:0] b);
        logic [BIN_W-1:0]   diff;
        logic [DEN_W-1:0]   den;
        logic [2*BIN_W-1:0] sq;
        logic [2*BIN_W-1:0] quo;
        diff = (a >= b) ? (a - b) : (b - a);
        den  = {1'b0, a} + {1'b0, b};
        if (den == '0) begin
            return '0;
        end
        sq  = {{BIN_W{1'b0}}, diff} * {{BIN_W{1'b0}}, diff};
        quo = sq / {{(2*BIN_W-DEN_W){1'b0}}, den};
        return quo[BIN_W-1:0];
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [DIST_W:0] grown;
        t_chi_result     exp_r;
        if (!i_rst_n) begin
            hist_total = '0;
            hist_sat   = 1'b0;
            expected_distances.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                grown = {1'b0, hist_total}
                      + {{(DIST_W+1-BIN_W){1'b0}}, chi_term(i_bin_first, i_bin_second)};
                if (grown > {1'b0, TOTAL_MAX}) begin
                    hist_total = TOTAL_MAX;
                    hist_sat   = 1'b1;
                end else begin
                    hist_total = grown[DIST_W-1:0];
                    if (hist_total == TOTAL_MAX) begin
                        hist_sat = 1'b1;
                    end
                end
                if (i_last_bin) begin
                    exp_r.distance  = hist_total;
                    exp_r.saturated = hist_sat;
                    expected_distances = {expected_distances, exp_r};
                    hist_total = '0;
                    hist_sat   = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_distances.size() == 0) begin
                    note_error($sformatf("unexpected result word: distance %012h saturated %b",
                                         i_distance, i_saturated));
                end else begin
                    exp_r = expected_distances.pop_front();
                    if (i_distance !== exp_r.distance) begin
                        note_error($sformatf("distance: expected %012h, got %012h",
                                             exp_r.distance, i_distance));
                    end
                    if (i_saturated !== exp_r.saturated) begin
                        note_error($sformatf("saturated: expected %b, got %b",
                                             exp_r.saturated, i_saturated));
                    end
                end
            end
        end
        o_error_count <= err_count;
        o_pending     <= expected_distances.size();
    end

endmodule

// ===== tb/sv/chi_square_histogram_distance_core_tb.sv =====
`timescale 1ns / 1ps

module chi_square_histogram_distance_core_tb;
    import chsq_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASE_PAIRS    = 170;
    // run of max-quotient pairs with no last flag
    localparam int OVERLONG_PAIRS = 24;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BIN_W-1:0]  bin_first;
    logic [BIN_W-1:0]  bin_second;
    logic              last_bin;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DIST_W-1:0] distance;
    logic              saturated;

    int error_count;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int burst_left = 0;
    int pairs_sent = 0;
    int cycle_count = 0;

    chi_square_histogram_distance_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_bin_first  (bin_first),
        .i_bin_second (bin_second),
        .i_last_bin   (last_bin),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_distance   (distance),
        .o_saturated  (saturated)
    );

    chi_square_histogram_distance_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_bin_first   (bin_first),
        .i_bin_second  (bin_second),
        .i_last_bin    (last_bin),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_distance    (distance),
        .i_saturated   (saturated),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver stalls in bursts so a held result can block a last pair
    always @(posedge clk) begin
        if (burst_left > 0) begin
            burst_left <= burst_left - 1;
        end else begin
            burst_left <= $urandom_range(1, 59);
            out_stall  <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pair(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                             input logic last);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 70);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        bin_first  <= a;
        bin_second <= b;
        last_bin   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pairs_sent++;
    endtask

    // hold off the sender until every distance has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_histogram();
        int len;
        int pick;
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            len = $urandom_range(1, 6);
        else if (pick < 97)
            len = $urandom_range(7, 30);
        else
            len = $urandom_range(31, 120);
        for (int i = 0; i < len; i++) begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 9))
                4: begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
                5: b = a;
                6: if ($urandom_range(0, 1)) a = '0; else b = '0;
                7: begin
                    a = '0;
                    b = '0;
                end
                8: b = a ^ $urandom_range(0, 15);
                9: begin
                    a = a | 32'hFFFF_0000;
                    b = b >> $urandom_range(0, 31);
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial begin
        int start;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        bin_first  = '0;
        bin_second = '0;
        last_bin   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, zero sum, exact fractions
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
        send_pair(32'h0001_0000, 32'h0003_0000, 1'b0);
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0005, 32'h0000_0003, 1'b1);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        for (int i = 0; i < 3; i++) send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        wait_drained();

        // long stream of maximum quotients, then small ones to close it
        for (int i = 0; i < OVERLONG_PAIRS; i++) send_pair(32'hFFFF_FFFF, 32'h0, 1'b0);
        send_pair(32'h0000_FFFF, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
        // flag must be clear for the next histogram
        send_pair(32'h0000_0003, 32'h0000_0001, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            start = pairs_sent;
            while (pairs_sent - start < PHASE_PAIRS) begin
                send_random_histogram();
                if ($urandom_range(0, 24) == 0) wait_drained();
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (100) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
